[rtl/core/point_scale_rotate_translate_2d_core_macros.svh]
// Assertion macros for the 2-D point transform core and its checker.
// Depends on nothing; the using module must have aclk and aresetn in scope.
`ifndef POINT_SCALE_ROTATE_TRANSLATE_2D_CORE_MACROS_SVH
`define POINT_SCALE_ROTATE_TRANSLATE_2D_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSRT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/psrt_pkg.sv]
// Shared constants for the 2-D point scale, rotate and translate core.
// Used by the trig unit, the datapath, the top level and the checker.
package psrt_pkg;

    localparam int COORD_W      = 32;
    localparam int SCALE_W      = 16;
    localparam int SCALE_FRAC   = 8;
    localparam int ANGLE_W      = 17;
    localparam int SCALED_W     = COORD_W + SCALE_W - SCALE_FRAC;
    localparam int TRIG_FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int S_TDATA_W    = 2 * COORD_W;
    localparam int M_TDATA_W    = 2 * COORD_W;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ANGLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOC_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOC_Y     = 3'd4;

    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

endpackage

[rtl/core/psrt_trig.sv]
// Sequential sine and cosine unit, run once for every write of the angle register.
// Taylor series in Q1.30 on one shared multiplier, constant divisions by reciprocal; uses psrt_pkg.
module psrt_trig #(
    parameter int TRIG_FRAC_BITS = psrt_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [psrt_pkg::ANGLE_W-1:0] angle,
    output logic                                busy,
    output logic signed [TRIG_FRAC_BITS+1:0]    sin_term,
    output logic signed [TRIG_FRAC_BITS+1:0]    cos_term
);
    import psrt_pkg::*;

    localparam int TW     = TRIG_FRAC_BITS + 2;
    localparam int VW     = 31;
    localparam int PRW    = 2 * VW;
    localparam int ACCW   = 48;
    localparam int SHW    = 6;
    localparam int RND_SH = 30 - TRIG_FRAC_BITS;

    localparam logic [VW-1:0]   ONE      = 31'h4000_0000;
    localparam logic [31:0]     RND_HALF = 32'd1 << (29 - TRIG_FRAC_BITS);
    localparam logic [VW-1:0]   C_HI     = 31'd73204;
    localparam logic [VW-1:0]   C_LO     = 31'd54346;
    localparam logic signed [17:0] TURN_S     = 18'sd46080;
    localparam logic signed [17:0] TWO_TURN_S = 18'sd92160;
    localparam logic [15:0]     QUARTER   = 16'd11520;
    localparam logic [15:0]     HALF_TURN = 16'd23040;
    localparam logic [15:0]     THREE_Q   = 16'd34560;
    localparam logic [15:0]     EIGHTH    = 16'd5760;
    localparam logic [3:0]      SIN_LAST  = 4'd4;
    localparam logic [3:0]      COS_LAST  = 4'd10;

    typedef enum logic [3:0] {
        S_IDLE, S_WRAP, S_QUAD, S_XHI, S_XLO, S_XSUM, S_X2, S_X2W,
        S_MUL, S_DIV, S_DIVDONE, S_SIN, S_SINW
    } state_t;

    typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_t;

    // A division by the series constant d is a multiply by ceil(2^(30+l)/d) and a right
    // shift by 30+l, where 2^l is the smallest power of two not below d. This is exact
    // for every dividend below 2^30, which holds for all terms of the series.
    function automatic logic [VW-1:0] step_recip(input logic [3:0] k);
        case (k)
            4'd0:    return 31'd1249445032;
            4'd1:    return 31'd1908874354;
            4'd2:    return 31'd1636178018;
            4'd3:    return 31'd1717986919;
            4'd4:    return 31'd1431655766;
            4'd5:    return 31'd2082408386;
            4'd6:    return 31'd1527099484;
            4'd7:    return 31'd1227133514;
            4'd8:    return 31'd1145324613;
            4'd9:    return 31'd1431655766;
            default: return 31'd1073741824;
        endcase
    endfunction

    function automatic logic [SHW-1:0] step_shift(input logic [3:0] k);
        case (k)
            4'd0:    return 6'd37;
            4'd1:    return 6'd37;
            4'd2:    return 6'd36;
            4'd3:    return 6'd35;
            4'd4:    return 6'd33;
            4'd5:    return 6'd38;
            4'd6:    return 6'd37;
            4'd7:    return 6'd36;
            4'd8:    return 6'd35;
            4'd9:    return 6'd34;
            default: return 6'd31;
        endcase
    endfunction

    function automatic logic [TW-1:0] to_trig(input logic [VW-1:0] v);
        logic [31:0] sum;
        sum = {1'b0, v} + RND_HALF;
        return TW'(sum >> RND_SH);
    endfunction

    state_t               state_reg;
    quad_t                quad_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic [15:0]          a_reg;
    logic                 swap_reg;
    logic [12:0]          t_reg;
    logic [PRW-1:0]       prod_reg;
    logic [ACCW-1:0]      acc_reg;
    logic [VW-1:0]        x_reg;
    logic [VW-1:0]        x2_reg;
    logic [VW-1:0]        u_reg;
    logic [VW-1:0]        u_sin_reg;
    logic [VW-1:0]        c_raw_reg;
    logic [3:0]           step_reg;
    logic signed [TW-1:0] sin_reg;
    logic signed [TW-1:0] cos_reg;

    logic signed [17:0]   ang_ext;
    logic signed [17:0]   wrap_full;
    logic [15:0]          r_full;
    quad_t                quad_next;
    logic                 swap_next;
    logic [12:0]          t_next;
    logic [VW-1:0]        mul_a;
    logic [VW-1:0]        mul_b;
    logic [ACCW-1:0]      x_sum;
    logic [VW-1:0]        recip;
    logic [SHW-1:0]       div_shift;
    logic [VW-1:0]        quo;
    logic [VW-1:0]        u_new;
    logic signed [TW-1:0] s_mag;
    logic signed [TW-1:0] c_mag;
    logic signed [TW-1:0] s0;
    logic signed [TW-1:0] c0;

    always_comb begin
        ang_ext = {angle_reg[ANGLE_W-1], angle_reg};
        if (ang_ext < -TURN_S) begin
            wrap_full = ang_ext + TWO_TURN_S;
        end else if (ang_ext < 18'sd0) begin
            wrap_full = ang_ext + TURN_S;
        end else if (ang_ext >= TURN_S) begin
            wrap_full = ang_ext - TURN_S;
        end else begin
            wrap_full = ang_ext;
        end
    end

    always_comb begin
        if (a_reg < QUARTER) begin
            quad_next = QUAD_I;
            r_full    = a_reg;
        end else if (a_reg < HALF_TURN) begin
            quad_next = QUAD_II;
            r_full    = a_reg - QUARTER;
        end else if (a_reg < THREE_Q) begin
            quad_next = QUAD_III;
            r_full    = a_reg - HALF_TURN;
        end else begin
            quad_next = QUAD_IV;
            r_full    = a_reg - THREE_Q;
        end
        swap_next = r_full > EIGHTH;
        t_next    = swap_next ? 13'(QUARTER - r_full) : r_full[12:0];
    end

    always_comb begin
        case (state_reg)
            S_XHI: begin
                mul_a = {18'd0, t_reg};
                mul_b = C_HI;
            end
            S_XLO: begin
                mul_a = {18'd0, t_reg};
                mul_b = C_LO;
            end
            S_X2: begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            S_MUL: begin
                mul_a = x2_reg;
                mul_b = u_reg;
            end
            S_DIV: begin
                mul_a = prod_reg[60:30];
                mul_b = recip;
            end
            S_SIN: begin
                mul_a = x_reg;
                mul_b = u_sin_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign x_sum     = acc_reg + ACCW'(prod_reg);
    assign recip     = step_recip(step_reg);
    assign div_shift = step_shift(step_reg);
    assign quo       = VW'(prod_reg >> div_shift);
    assign u_new     = ONE - quo;

    always_comb begin
        s_mag = to_trig(prod_reg[60:30]);
        c_mag = to_trig(c_raw_reg);
        s0    = swap_reg ? c_mag : s_mag;
        c0    = swap_reg ? s_mag : c_mag;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sin_reg   <= '0;
            cos_reg   <= TW'(1) << TRIG_FRAC_BITS;
        end else if (start) begin
            angle_reg <= angle;
            state_reg <= S_WRAP;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    state_reg <= S_IDLE;
                end
                S_WRAP: begin
                    a_reg     <= wrap_full[15:0];
                    state_reg <= S_QUAD;
                end
                S_QUAD: begin
                    quad_reg  <= quad_next;
                    swap_reg  <= swap_next;
                    t_reg     <= t_next;
                    state_reg <= S_XHI;
                end
                S_XHI: begin
                    state_reg <= S_XLO;
                end
                S_XLO: begin
                    acc_reg   <= ACCW'(prod_reg) << 17;
                    state_reg <= S_XSUM;
                end
                S_XSUM: begin
                    x_reg     <= x_sum[46:16];
                    state_reg <= S_X2;
                end
                S_X2: begin
                    state_reg <= S_X2W;
                end
                S_X2W: begin
                    x2_reg    <= prod_reg[60:30];
                    u_reg     <= ONE;
                    step_reg  <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    state_reg <= S_DIVDONE;
                end
                S_DIVDONE: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == COS_LAST) begin
                        c_raw_reg <= u_new;
                        state_reg <= S_SIN;
                    end else if (step_reg == SIN_LAST) begin
                        u_sin_reg <= u_new;
                        u_reg     <= ONE;
                        state_reg <= S_MUL;
                    end else begin
                        u_reg     <= u_new;
                        state_reg <= S_MUL;
                    end
                end
                S_SIN: begin
                    state_reg <= S_SINW;
                end
                S_SINW: begin
                    case (quad_reg)
                        QUAD_I: begin
                            sin_reg <= s0;
                            cos_reg <= c0;
                        end
                        QUAD_II: begin
                            sin_reg <= c0;
                            cos_reg <= -s0;
                        end
                        QUAD_III: begin
                            sin_reg <= -s0;
                            cos_reg <= -c0;
                        end
                        default: begin
                            sin_reg <= -c0;
                            cos_reg <= s0;
                        end
                    endcase
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = state_reg != S_IDLE;
    assign sin_term = sin_reg;
    assign cos_term = cos_reg;

endmodule

[rtl/core/psrt_datapath.sv]
// Five-stage point pipeline: scale, round, rotate products, round, translate and saturate.
// Per-stage valid bits with local ready; depends on psrt_pkg.
module psrt_datapath #(
    parameter int TRIG_FRAC_BITS = psrt_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [psrt_pkg::COORD_W-1:0] in_x,
    input  logic signed [psrt_pkg::COORD_W-1:0] in_y,
    input  logic signed [psrt_pkg::SCALE_W-1:0] scale_x,
    input  logic signed [psrt_pkg::SCALE_W-1:0] scale_y,
    input  logic signed [psrt_pkg::COORD_W-1:0] loc_x,
    input  logic signed [psrt_pkg::COORD_W-1:0] loc_y,
    input  logic signed [TRIG_FRAC_BITS+1:0]    sin_term,
    input  logic signed [TRIG_FRAC_BITS+1:0]    cos_term,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [psrt_pkg::COORD_W-1:0] out_x,
    output logic signed [psrt_pkg::COORD_W-1:0] out_y,
    output logic                                out_sat
);
    import psrt_pkg::*;

    localparam int TW  = TRIG_FRAC_BITS + 2;
    localparam int P1W = COORD_W + SCALE_W;
    localparam int SXW = SCALED_W;
    localparam int PW  = SXW + TW;
    localparam int SW  = PW + 1;
    localparam int RW  = SW - TRIG_FRAC_BITS;
    localparam int OW  = RW + 1;

    localparam logic [P1W-1:0] SCALE_HALF = P1W'(1) << (SCALE_FRAC - 1);
    localparam logic [SW-1:0]  TRIG_HALF  = SW'(1) << (TRIG_FRAC_BITS - 1);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    logic signed [P1W-1:0] p1x_reg, p1y_reg, p1x_next, p1y_next;
    logic signed [SXW-1:0] sx_reg, sy_reg;
    logic [P1W-1:0]        s2x_sum, s2y_sum;
    logic signed [PW-1:0]  pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic signed [PW-1:0]  pxc_next, pys_next, pxs_next, pyc_next;
    logic [SW-1:0]         s4x_sum, s4y_sum;
    logic [RW-1:0]         rx_reg, ry_reg;
    logic [OW-1:0]         ox_sum, oy_sum;
    logic                  fit_x, fit_y;
    logic [COORD_W-1:0]    ox_next, oy_next;
    logic [COORD_W-1:0]    out_x_reg, out_y_reg;
    logic                  sat_reg;
    logic [SCALE_W-2:0]    kx, ky;

    assign rdy5 = !v5_reg || out_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign kx       = scale_x[SCALE_W-1] ? '0 : scale_x[SCALE_W-2:0];
    assign ky       = scale_y[SCALE_W-1] ? '0 : scale_y[SCALE_W-2:0];
    assign p1x_next = in_x * $signed({1'b0, kx});
    assign p1y_next = in_y * $signed({1'b0, ky});

    assign s2x_sum = p1x_reg + SCALE_HALF;
    assign s2y_sum = p1y_reg + SCALE_HALF;

    assign pxc_next = sx_reg * cos_term;
    assign pys_next = sy_reg * sin_term;
    assign pxs_next = sx_reg * sin_term;
    assign pyc_next = sy_reg * cos_term;

    assign s4x_sum = {pxc_reg[PW-1], pxc_reg} - {pys_reg[PW-1], pys_reg} + TRIG_HALF;
    assign s4y_sum = {pxs_reg[PW-1], pxs_reg} + {pyc_reg[PW-1], pyc_reg} + TRIG_HALF;

    always_comb begin
        ox_sum  = {rx_reg[RW-1], rx_reg} + {{(OW-COORD_W){loc_x[COORD_W-1]}}, loc_x};
        oy_sum  = {ry_reg[RW-1], ry_reg} + {{(OW-COORD_W){loc_y[COORD_W-1]}}, loc_y};
        fit_x   = (&ox_sum[OW-1:COORD_W-1]) || !(|ox_sum[OW-1:COORD_W-1]);
        fit_y   = (&oy_sum[OW-1:COORD_W-1]) || !(|oy_sum[OW-1:COORD_W-1]);
        ox_next = fit_x ? ox_sum[COORD_W-1:0] : (ox_sum[OW-1] ? COORD_MIN : COORD_MAX);
        oy_next = fit_y ? oy_sum[COORD_W-1:0] : (oy_sum[OW-1] ? COORD_MIN : COORD_MAX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            p1x_reg <= p1x_next;
            p1y_reg <= p1y_next;
        end
        if (rdy2 && v1_reg) begin
            sx_reg <= s2x_sum[P1W-1:SCALE_FRAC];
            sy_reg <= s2y_sum[P1W-1:SCALE_FRAC];
        end
        if (rdy3 && v2_reg) begin
            pxc_reg <= pxc_next;
            pys_reg <= pys_next;
            pxs_reg <= pxs_next;
            pyc_reg <= pyc_next;
        end
        if (rdy4 && v3_reg) begin
            rx_reg <= s4x_sum[SW-1:TRIG_FRAC_BITS];
            ry_reg <= s4y_sum[SW-1:TRIG_FRAC_BITS];
        end
        if (rdy5 && v4_reg) begin
            out_x_reg <= ox_next;
            out_y_reg <= oy_next;
            sat_reg   <= !fit_x || !fit_y;
        end
    end

    assign in_ready  = rdy1;
    assign out_valid = v5_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_sat   = sat_reg;

endmodule

[rtl/core/point_scale_rotate_translate_2d_core.sv]
// Top level of the 2-D point scale, rotate and translate core; holds the configuration
// registers and joins psrt_trig and psrt_datapath. Depends on psrt_pkg.
//
// Points arrive on the s_ stream, one per transaction, and leave on the m_ stream in the
// same order, one result per point. Each coordinate is scaled by its Q8.8 scale (negative
// scales act as zero), rotated by the stored sine and cosine, translated and saturated;
// m_tuser is set when either coordinate was clipped.
// The pipeline has five register stages, and one point per cycle is sustained while the
// receiver keeps taking results and no configuration write or sine and cosine run holds s_tready.
// A stalled receiver holds the output stage; the empty stages ahead of it keep taking
// points until the pipeline is full, and then s_tready falls. Nothing is dropped.
// A write to the angle register starts the sine and cosine sequencer, which runs on one
// shared multiplier, dividing by constants through reciprocals; s_tready stays low
// while the sequencer is busy and in every cycle with a configuration write.
// Reset (aresetn low, synchronous) empties the pipeline, loads the register reset values
// and sets the rotation to zero degrees.
module point_scale_rotate_translate_2d_core #(
    parameter int TRIG_FRAC_BITS = psrt_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [psrt_pkg::S_TDATA_W-1:0]         s_tdata,   // in_x, in_y
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [psrt_pkg::M_TDATA_W-1:0]         m_tdata,   // out_x, out_y
    output logic                                   m_tuser,   // saturated
    input  logic                                   cfg_wr_en,
    input  logic [psrt_pkg::CFG_IDX_W-1:0]         cfg_wr_idx,
    input  logic [psrt_pkg::CFG_DATA_W-1:0]        cfg_wr_data
);
    import psrt_pkg::*;

    localparam int TW = TRIG_FRAC_BITS + 2;

    logic signed [SCALE_W-1:0] scale_x_reg;
    logic signed [SCALE_W-1:0] scale_y_reg;
    logic signed [COORD_W-1:0] loc_x_reg;
    logic signed [COORD_W-1:0] loc_y_reg;

    logic                      trig_start;
    logic                      trig_busy;
    logic signed [TW-1:0]      sin_term;
    logic signed [TW-1:0]      cos_term;
    logic                      in_open;
    logic                      dp_in_ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_x_reg <= 16'sd256;
            scale_y_reg <= 16'sd256;
            loc_x_reg   <= '0;
            loc_y_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_idx)
                REG_SCALE_X: scale_x_reg <= cfg_wr_data[SCALE_W-1:0];
                REG_SCALE_Y: scale_y_reg <= cfg_wr_data[SCALE_W-1:0];
                REG_LOC_X:   loc_x_reg   <= cfg_wr_data[COORD_W-1:0];
                REG_LOC_Y:   loc_y_reg   <= cfg_wr_data[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign trig_start = cfg_wr_en && (cfg_wr_idx == REG_ROT_ANGLE);
    assign in_open    = !trig_busy && !cfg_wr_en;
    assign s_tready   = dp_in_ready && in_open;

    psrt_trig #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (trig_start),
        .angle    (cfg_wr_data[ANGLE_W-1:0]),
        .busy     (trig_busy),
        .sin_term (sin_term),
        .cos_term (cos_term)
    );

    psrt_datapath #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid && in_open),
        .in_ready  (dp_in_ready),
        .in_x      (s_tdata[COORD_W-1:0]),
        .in_y      (s_tdata[2*COORD_W-1:COORD_W]),
        .scale_x   (scale_x_reg),
        .scale_y   (scale_y_reg),
        .loc_x     (loc_x_reg),
        .loc_y     (loc_y_reg),
        .sin_term  (sin_term),
        .cos_term  (cos_term),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_sat   (m_tuser)
    );

    assign m_tdata = {out_y, out_x};

endmodule

[rtl/core/psrt_checker.sv]
// Port-level checker for the 2-D point transform core, bound to the top level below.
// Depends on psrt_pkg and the core's assertion macro header.
`include "point_scale_rotate_translate_2d_core_macros.svh"

module psrt_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [psrt_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                              m_tuser,
    input logic                              cfg_wr_en,
    input logic [psrt_pkg::CFG_IDX_W-1:0]    cfg_wr_idx
);
    import psrt_pkg::*;

    `PSRT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Result transaction changed while stalled.")

    `PSRT_ASSERT_SAME(a_cfg_blocks_input, cfg_wr_en, !s_tready, "Input accepted during a configuration write.")

    `PSRT_ASSERT_NEXT(a_angle_blocks_input, cfg_wr_en && (cfg_wr_idx == REG_ROT_ANGLE), !s_tready, "Input accepted while sine and cosine are being computed.")

    `PSRT_ASSERT_SAME(a_sat_at_limit, m_tvalid && m_tuser, (m_tdata[31:0] == COORD_MAX) || (m_tdata[31:0] == COORD_MIN) || (m_tdata[63:32] == COORD_MAX) || (m_tdata[63:32] == COORD_MIN), "Saturation flag set with no coordinate at a limit.")

endmodule

bind point_scale_rotate_translate_2d_core psrt_checker u_psrt_checker (.*);

[bench/point_scale_rotate_translate_2d_core_tb.sv]
// Self-checking testbench for point_scale_rotate_translate_2d_core: directed and random
// points under changing scale, angle and location, each result checked against a predictor.
// Depends on psrt_pkg and the core RTL only.
module point_scale_rotate_translate_2d_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psrt_pkg::*;

    localparam int TRIG_FRAC = TRIG_FRAC_BITS_DEF;
    localparam int TURN_UNITS = 46080;
    localparam int QUARTER_UNITS = 11520;
    localparam int EIGHTH_UNITS = 5760;
    localparam longint unsigned RAD_PER_UNIT = 64'd9595049034;
    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint COORD_HI = 64'sd2147483647;
    localparam longint COORD_LO = -64'sd2147483648;
    localparam int SETTLE = 12;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               sat;
    } point_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_wr_idx;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;

    logic signed [SCALE_W-1:0] scale_x_q;
    logic signed [SCALE_W-1:0] scale_y_q;
    logic signed [ANGLE_W-1:0] angle_q;
    logic signed [COORD_W-1:0] loc_x_q;
    logic signed [COORD_W-1:0] loc_y_q;
    longint                    cos_q;
    longint                    sin_q;

    point_t pending_points[$];
    int     error_count = 0;
    bit     sender_gaps = 1'b1;
    bit     sink_stalls = 1'b1;

    point_scale_rotate_translate_2d_core #(
        .TRIG_FRAC_BITS(TRIG_FRAC)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_idx(cfg_wr_idx),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("point_scale_rotate_translate_2d_core_tb: errors");
        $finish;
    end

    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b) >> 30;
    endfunction

    function automatic longint to_trig(longint unsigned q);
        return longint'((q + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC));
    endfunction

    function automatic void eighth_sincos(input int t, output longint s, output longint c);
        longint unsigned x, x2, u;
        x = (longint'(t) * RAD_PER_UNIT) >> 16;
        x2 = q30_mul(x, x);
        u = Q30_ONE - x2 / 110;
        u = Q30_ONE - q30_mul(x2, u) / 72;
        u = Q30_ONE - q30_mul(x2, u) / 42;
        u = Q30_ONE - q30_mul(x2, u) / 20;
        u = Q30_ONE - q30_mul(x2, u) / 6;
        s = to_trig(q30_mul(x, u));
        u = Q30_ONE - x2 / 132;
        u = Q30_ONE - q30_mul(x2, u) / 90;
        u = Q30_ONE - q30_mul(x2, u) / 56;
        u = Q30_ONE - q30_mul(x2, u) / 30;
        u = Q30_ONE - q30_mul(x2, u) / 12;
        c = to_trig(Q30_ONE - q30_mul(x2, u) / 2);
    endfunction

    function automatic void refresh_rotation();
        int     a, quad, r;
        longint s0, c0;
        a = int'(angle_q) % TURN_UNITS;
        if (a < 0) a += TURN_UNITS;
        quad = a / QUARTER_UNITS;
        r = a % QUARTER_UNITS;
        if (r <= EIGHTH_UNITS) eighth_sincos(r, s0, c0);
        else eighth_sincos(QUARTER_UNITS - r, c0, s0);
        case (quad)
            0: begin sin_q = s0;  cos_q = c0;  end
            1: begin sin_q = c0;  cos_q = -s0; end
            2: begin sin_q = -s0; cos_q = -c0; end
            default: begin sin_q = -c0; cos_q = s0; end
        endcase
    endfunction

    function automatic longint round_shift(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(longint v, inout logic clipped);
        if (v > COORD_HI) begin
            clipped = 1'b1;
            return COORD_MAX;
        end
        if (v < COORD_LO) begin
            clipped = 1'b1;
            return COORD_MIN;
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic point_t transform_point(logic signed [COORD_W-1:0] px,
                                               logic signed [COORD_W-1:0] py);
        longint kx, ky, sx, sy, rx, ry;
        point_t res;
        kx = scale_x_q;
        ky = scale_y_q;
        if (kx < 0) kx = 0;
        if (ky < 0) ky = 0;
        sx = round_shift(longint'(px) * kx, SCALE_FRAC);
        sy = round_shift(longint'(py) * ky, SCALE_FRAC);
        rx = round_shift(sx * cos_q - sy * sin_q, TRIG_FRAC);
        ry = round_shift(sx * sin_q + sy * cos_q, TRIG_FRAC);
        res.sat = 1'b0;
        res.x = clamp_coord(rx + longint'(loc_x_q), res.sat);
        res.y = clamp_coord(ry + longint'(loc_y_q), res.sat);
        return res;
    endfunction

    task automatic note_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge aclk) begin : result_check
        point_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_points.size() == 0) begin
                note_error($sformatf("unexpected transaction tdata=%h tuser=%b",
                                     m_tdata, m_tuser));
            end else begin
                want = pending_points.pop_front();
                if (m_tdata[COORD_W-1:0] !== want.x)
                    note_error($sformatf("out_x got %h want %h", m_tdata[COORD_W-1:0], want.x));
                if (m_tdata[2*COORD_W-1:COORD_W] !== want.y)
                    note_error($sformatf("out_y got %h want %h",
                                         m_tdata[2*COORD_W-1:COORD_W], want.y));
                if (m_tuser !== want.sat)
                    note_error($sformatf("saturated got %b want %b", m_tuser, want.sat));
            end
        end
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_stalls && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {py, px};
        do @(posedge aclk); while (!s_tready);
        pending_points.push_back(transform_point(px, py));
    endtask

    task automatic wait_idle(input int settle);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_points.size() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_wr_idx <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SCALE_X: scale_x_q = data[SCALE_W-1:0];
            REG_SCALE_Y: scale_y_q = data[SCALE_W-1:0];
            REG_ROT_ANGLE: begin
                angle_q = data[ANGLE_W-1:0];
                refresh_rotation();
            end
            REG_LOC_X: loc_x_q = data;
            REG_LOC_Y: loc_y_q = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_scale(input logic [SCALE_W-1:0] kx, input logic [SCALE_W-1:0] ky);
        write_register(REG_SCALE_X, {16'($urandom), kx});
        write_register(REG_SCALE_Y, {16'($urandom), ky});
    endtask

    task automatic set_angle(input logic [ANGLE_W-1:0] a);
        write_register(REG_ROT_ANGLE, {15'($urandom), a});
    endtask

    task automatic set_loc(input logic [COORD_W-1:0] lx, input logic [COORD_W-1:0] ly);
        write_register(REG_LOC_X, lx);
        write_register(REG_LOC_Y, ly);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        int v;
        v = int'($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000;
        case ($urandom_range(0, 7))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 4))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    3: return '1;
                    default: return 32'd1;
                endcase
            end
            3: return $urandom_range(0, 32'hFFFF) | (int'($urandom_range(0, 1)) << 31);
            default: return v;
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 6))
            0: return 16'h8000 | 16'($urandom);
            1: return 16'($urandom);
            2: return 16'($urandom_range(0, 1024));
            3: return 16'($urandom_range(200, 300));
            4: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
            default: return 16'd256;
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] pick_angle();
        int a;
        a = int'($urandom_range(0, 11)) * EIGHTH_UNITS + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) a = -a;
        case ($urandom_range(0, 2))
            0: return a[ANGLE_W-1:0];
            1: return 17'($urandom);
            default: return 17'(int'($urandom_range(0, 2 * TURN_UNITS)) - TURN_UNITS);
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_loc();
        int v;
        v = int'($urandom_range(0, 32'hFF_FFFF)) - 32'sh80_0000;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return ($urandom_range(0, 1)) ? COORD_MAX : COORD_MIN;
            2: return '0;
            default: return v;
        endcase
    endfunction

    task automatic test_identity_reset();
        send_point('0, '0);
        send_point(COORD_MAX, COORD_MIN);
        send_point(COORD_MIN, COORD_MAX);
        send_point('1, 32'd1);
        send_point(32'h0001_0000, 32'hFFFF_8000);
    endtask

    task automatic test_scale_clamp();
        wait_idle(SETTLE);
        set_scale(16'h7FFF, 16'h8000);
        send_point(COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, 32'h1234_5678);
        send_point(32'h0000_0100, '1);
        wait_idle(SETTLE);
        // Half a unit times an odd coordinate lands exactly on a rounding tie.
        set_scale(16'h0080, 16'hFFFF);
        send_point(32'd3, 32'd7);
        send_point(-32'sd3, -32'sd7);
    endtask

    task automatic test_translate_saturation();
        wait_idle(SETTLE);
        set_scale(16'd256, 16'd256);
        set_loc(COORD_MAX, COORD_MIN);
        send_point(32'd1, '1);
        send_point('1, 32'd1);
        send_point('0, '0);
    endtask

    task automatic test_angle_wrap();
        int angles[$] = '{0, 5760, 5761, 11519, 11520, 23040, 34560, 46080, -46080, -1,
                          65535, -65536};
        wait_idle(SETTLE);
        set_loc(32'h0003_0000, 32'hFFFE_0000);
        foreach (angles[i]) begin
            wait_idle(SETTLE);
            set_angle(angles[i][ANGLE_W-1:0]);
            send_point(32'h0001_0000, 32'h0000_8000);
        end
    endtask

    task automatic test_unmapped_index();
        wait_idle(SETTLE);
        for (int i = int'(REG_LOC_Y) + 1; i < (1 << CFG_IDX_W); i++)
            write_register(CFG_IDX_W'(i), $urandom);
        send_point(32'h0002_0000, 32'hFFFF_0000);
        send_point(pick_coord(), pick_coord());
    endtask

    task automatic test_random_traffic(input int phases, input int per_phase);
        int pause_at;
        for (int p = 0; p < phases; p++) begin
            wait_idle(SETTLE);
            if (p == 0) begin
                set_scale(16'h7FFF, 16'h7FFF);
                set_loc(COORD_MAX, COORD_MAX);
                set_angle(17'h0FFFF);
            end else if (p == 1) begin
                set_scale(16'h8000, 16'h0000);
                set_loc(COORD_MIN, COORD_MIN);
                set_angle(17'h10000);
            end else begin
                set_scale(pick_scale(), pick_scale());
                set_loc(pick_loc(), pick_loc());
                set_angle(pick_angle());
            end
            pause_at = $urandom_range(1, per_phase - 1);
            for (int i = 0; i < per_phase; i++) begin
                if (i == pause_at) wait_idle(0);
                send_point(pick_coord(), pick_coord());
            end
        end
    endtask

    task automatic test_streaming_no_idle(input int count);
        wait_idle(SETTLE);
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        set_scale(pick_scale(), pick_scale());
        set_loc(pick_loc(), pick_loc());
        set_angle(pick_angle());
        for (int i = 0; i < count; i++)
            send_point(pick_coord(), pick_coord());
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_idx <= '0;
        cfg_wr_data <= '0;
        scale_x_q = 16'sd256;
        scale_y_q = 16'sd256;
        angle_q = '0;
        loc_x_q = '0;
        loc_y_q = '0;
        cos_q = longint'(1) << TRIG_FRAC;
        sin_q = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_identity_reset();
        test_scale_clamp();
        test_translate_saturation();
        test_angle_wrap();
        test_unmapped_index();
        test_random_traffic(12, 65);
        test_streaming_no_idle(100);

        wait_idle(SETTLE);
        if (error_count == 0 && pending_points.size() == 0) begin
            $display("point_scale_rotate_translate_2d_core_tb: clean");
        end else begin
            $display("point_scale_rotate_translate_2d_core_tb: errors");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/psrt_pkg.sv
rtl/core/psrt_trig.sv
rtl/core/psrt_datapath.sv
rtl/core/point_scale_rotate_translate_2d_core.sv
rtl/core/psrt_checker.sv
bench/point_scale_rotate_translate_2d_core_tb.sv
